### src/smpq_pkg.sv
package smpq_pkg;

  // Capacity of the queue and the widths that follow from it
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  // Field widths of the request and response
  localparam int CMD_W    = 2;
  localparam int PRIO_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One held entry
  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Broadcast from the control to every cell of the row
  typedef struct packed {
    logic                      push_en;
    logic                      pop_en;
    logic [OCC_W-1:0]          occ;
    entry_t                    new_entry;
  } cell_ctrl_t;

endpackage

### src/smpq_req_if.sv
interface smpq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [smpq_pkg::CMD_W-1:0]            cmd;
  logic signed [smpq_pkg::PRIO_W-1:0]    prio_in;
  logic signed [smpq_pkg::VALUE_W-1:0]   value_in;

  modport source (output valid, cmd, prio_in, value_in, input ready);
  modport sink (input valid, cmd, prio_in, value_in, output ready);
endinterface

### src/smpq_rsp_if.sv
interface smpq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [smpq_pkg::STATUS_W-1:0]         status;
  logic signed [smpq_pkg::PRIO_W-1:0]    head_prio;
  logic signed [smpq_pkg::VALUE_W-1:0]   head_value;
  logic [smpq_pkg::FILL_W-1:0]           fill_count;

  modport source (output valid, status, head_prio, head_value, fill_count, input ready);
  modport sink (input valid, status, head_prio, head_value, fill_count, output ready);
endinterface

### src/smpq_cell.sv
module smpq_cell (
  input  logic                       clk,
  input  logic [smpq_pkg::IDX_W-1:0] index,
  input  smpq_pkg::cell_ctrl_t       ctrl,
  input  smpq_pkg::entry_t           left_entry,
  input  logic                       left_keep,
  input  smpq_pkg::entry_t           right_entry,
  output smpq_pkg::entry_t           entry,
  output logic                       keep
);
  import smpq_pkg::*;

  logic   occupied;
  entry_t entry_next;

  // An occupied cell whose priority is not above the new one keeps its place,
  // so equal priorities stay first-in first-out
  assign occupied = OCC_W'(index) < ctrl.occ;
  assign keep     = occupied && (entry.prio <= ctrl.new_entry.prio);

  // Push: keep, take the new entry, or take the left neighbour's.
  // Pop: take the right neighbour's.
  always_comb begin
    entry_next = entry;
    if (ctrl.push_en) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = ctrl.new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### src/stable_min_priority_queue_unit.sv
// Sorted priority queue of DEPTH entries (16-bit signed priority, 32-bit
// value) held in a row of shift cells, smallest priority at the head and
// equal priorities served in push order. For each request (push, pop, peek)
// all cells compare against the pushed priority and shift in the
// same cycle, and the response is registered, so a new request is taken every
// cycle while the response side keeps up. Push on a full queue is dropped
// with status full; pop or peek on an empty queue returns status empty.
// Unused command codes leave the queue untouched and answer ok.
module stable_min_priority_queue_unit (
  input logic        clk,
  input logic        rst,
  smpq_req_if.sink   req,
  smpq_rsp_if.source rsp
);
  import smpq_pkg::*;

  logic [OCC_W-1:0] occ, occ_next;
  cell_ctrl_t       ctrl;
  entry_t           cell_entry [DEPTH];
  logic             cell_keep  [DEPTH];
  logic             accept;
  status_t          status_next;
  entry_t           head_next;

  logic                       rsp_valid;
  status_t                    rsp_status;
  entry_t                     rsp_head;
  logic [FILL_W-1:0]          rsp_fill;

  // Output register frees the request side whenever it is empty or drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Command decode
  always_comb begin
    status_next         = ST_OK;
    head_next           = '0;
    ctrl.push_en        = 1'b0;
    ctrl.pop_en         = 1'b0;
    ctrl.occ            = occ;
    ctrl.new_entry.prio  = req.prio_in;
    ctrl.new_entry.value = req.value_in;
    case (cmd_t'(req.cmd))
      CMD_PUSH: begin
        if (occ == OCC_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ctrl.push_en = accept;
        end
      end
      CMD_POP: begin
        if (occ == '0) begin
          status_next = ST_EMPTY;
        end else begin
          head_next   = cell_entry[0];
          ctrl.pop_en = accept;
        end
      end
      CMD_PEEK: begin
        if (occ == '0) begin
          status_next = ST_EMPTY;
        end else begin
          head_next = cell_entry[0];
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Occupancy count
  always_comb begin
    occ_next = occ;
    if (ctrl.push_en) begin
      occ_next = occ + OCC_W'(1);
    end else if (ctrl.pop_en) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  // Row of cells; head at cell 0, first cell sees a fixed left neighbour, last cell sees itself on the right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_keep;

    if (i == 0) begin : g_first
      // left keep is always set here, so the left entry is never taken
      assign left_entry = '0;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .index       (IDX_W'(i)),
      .ctrl        (ctrl),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      occ <= occ_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_head   <= head_next;
      rsp_fill   <= FILL_W'(occ_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.head_prio  = rsp_head.prio;
  assign rsp.head_value = rsp_head.value;
  assign rsp.fill_count = rsp_fill;

endmodule
